>>> sv/ndpr_pkg.sv
// Package for the dense neuron dot product with ReLU.
// Holds the stream and register codes, field widths and default sizes.
// No dependencies.
package ndpr_pkg;

   localparam int MAX_INPUTS_DEFAULT = 256;

   localparam int VALUE_W  = 16;
   localparam int SLOT_W   = 8;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 48;
   localparam int OUT_W    = 32;
   localparam int LEN_W    = 9;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // req_tuser kind codes
   localparam logic OP_WEIGHT  = 1'b0;
   localparam logic OP_ELEMENT = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_BIAS = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_RELU = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_LEN  = 2'd2;

   // status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_LEN_ERR = 1'b1;

   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 9'd256;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

>>> sv/neuron_dot_product_relu_top.sv
// Dense neuron: streamed row dot product with a stored weight vector, bias, ReLU.
// Depends on ndpr_pkg.
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ----------------------------------------------
//  req_     in   tvalid/tready        tdata: weight_slot[7:0], value[23:8]
//                                     tuser: operation   tlast: last_in_row
//  rsp_     out  tvalid/tready        tdata: neuron_output[31:0]  tuser: status
//  csr_     in   we (no handshake)    addr: register index, wdata: register value
//
// One transaction per cycle is taken while req_tready is high, weight writes and row elements alike.
// The weight store is a single-port synchronous memory read once per element;
// a row's result moves through stage 1, stage 2, the finishing stage and the response register.
// Reset is synchronous; it clears counters, flags, the accumulator and the configuration registers, not the store.
// Stages only stall behind a result that cannot move on; with rsp_tready held
// high the input is never stalled.
module neuron_dot_product_relu_top
   import ndpr_pkg::*;
#(
   parameter int MAX_INPUTS = MAX_INPUTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // weight_slot[7:0], value[23:8]
   input  logic                   req_tuser,   // operation
   input  logic                   req_tlast,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // neuron_output[31:0]
   output logic                   rsp_tuser,   // status
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata
);

   // address and count widths follow the store depth
   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int CW = $clog2(MAX_INPUTS + 1);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic signed [OUT_W-1:0] bias_ff;
   logic                    relu_ff;
   logic [LEN_W-1:0]        row_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff    <= '0;
         relu_ff    <= 1'b0;
         row_len_ff <= ROW_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BIAS: bias_ff    <= csr_wdata[OUT_W-1:0];
            CSR_RELU: relu_ff    <= csr_wdata[0];
            CSR_LEN:  row_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // a configured length above the store depth acts as the depth
   logic [CW-1:0] eff_len;
   assign eff_len = (32'(row_len_ff) > MAX_INPUTS) ? CW'(MAX_INPUTS) : CW'(row_len_ff);

   // ---------------------------------------------------------------
   // request field split
   // ---------------------------------------------------------------
   logic [SLOT_W-1:0]         req_slot;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_fire;
   logic                      wr_fire;
   logic                      elem_fire;

   assign req_slot  = req_tdata[SLOT_W-1:0];
   assign req_value = req_tdata[SLOT_W +: VALUE_W];
   assign req_fire  = req_tvalid && req_tready;
   assign wr_fire   = req_fire && (req_tuser == OP_WEIGHT);
   assign elem_fire = req_fire && (req_tuser == OP_ELEMENT);

   // ---------------------------------------------------------------
   // elastic stage enables, from the output back
   // ---------------------------------------------------------------
   logic rsp_tvalid_ff;
   logic fin_valid_ff;
   logic v1_ff, v2_ff;
   logic last2_ff;
   logic rsp_free;
   logic fin_en;
   logic en2;
   logic en1;

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign fin_en     = !fin_valid_ff || rsp_free;
   // only a row end needs room in the finishing stage
   assign en2        = !v2_ff || !last2_ff || fin_en;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   // ---------------------------------------------------------------
   // row bookkeeping at accept time
   // ---------------------------------------------------------------
   logic [CW-1:0] count_ff, count_in;
   logic          len_err_ff, len_err_in;
   logic          in_range;
   logic          err_sticky;
   logic          row_err;

   assign in_range   = (count_ff < eff_len);
   assign err_sticky = len_err_ff || !in_range;
   assign row_err    = err_sticky || (count_in != eff_len);

   always_comb begin
      count_in = in_range ? count_ff + CW'(1) : count_ff;
   end

   always_comb begin
      len_err_in = err_sticky;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         len_err_ff <= 1'b0;
      end else if (elem_fire) begin
         if (req_tlast) begin
            count_ff   <= '0;
            len_err_ff <= 1'b0;
         end else begin
            count_ff   <= count_in;
            len_err_ff <= len_err_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // weight store: one port, write on weight transactions, read on elements
   // ---------------------------------------------------------------
   logic [VALUE_W-1:0] weight_mem [MAX_INPUTS];
   logic [VALUE_W-1:0] weight_rd_ff;
   logic               slot_ok;

   assign slot_ok = (32'(req_slot) < MAX_INPUTS);

   always_ff @(posedge clock) begin
      if (wr_fire && slot_ok) begin
         weight_mem[AW'(req_slot)] <= req_value;
      end
      if (elem_fire) begin
         weight_rd_ff <= weight_mem[count_ff[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------
   // stage 1: element value, weight read data
   // ---------------------------------------------------------------
   logic signed [VALUE_W-1:0] value1_ff;
   logic                      mac1_ff, last1_ff, err1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= elem_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_fire) begin
         value1_ff <= req_value;
         mac1_ff   <= in_range;
         last1_ff  <= req_tlast;
         err1_ff   <= row_err;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: product
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0] prod_in, prod2_ff;
   logic                     mac2_ff, err2_ff;

   assign prod_in = value1_ff * $signed(weight_rd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         prod2_ff <= mac1_ff ? prod_in : '0;
         mac2_ff  <= mac1_ff;
         last2_ff <= last1_ff;
         err2_ff  <= err1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: saturating accumulate, hand off the row total on last
   // ---------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] fin_acc_ff;
   logic                    fin_err_ff;
   logic                    s2_fire;

   assign s2_fire = v2_ff && en2;
   assign acc_sum = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W+1-PROD_W){prod2_ff[PROD_W-1]}}, prod2_ff};

   always_comb begin
      if (!mac2_ff) begin
         acc_in = acc_ff;
      end else if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         if (s2_fire) begin
            acc_ff <= last2_ff ? '0 : acc_in;
         end
         if (fin_en) begin
            fin_valid_ff <= s2_fire && last2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && last2_ff) begin
         fin_acc_ff <= acc_in;
         fin_err_ff <= err2_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: bias, ReLU, zero on a length error, 32-bit saturation into the response register
   // ---------------------------------------------------------------
   logic signed [ACC_W:0]   fin_sum;
   logic signed [OUT_W-1:0] out_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic                    rsp_tuser_ff;

   assign fin_sum = {fin_acc_ff[ACC_W-1], fin_acc_ff}
                  + {{(ACC_W+1-OUT_W){bias_ff[OUT_W-1]}}, bias_ff};

   always_comb begin
      if (fin_err_ff) begin
         out_in = '0;
      end else if (relu_ff && fin_sum[ACC_W]) begin
         out_in = '0;
      end else if (!(&fin_sum[ACC_W:OUT_W-1]) && (|fin_sum[ACC_W:OUT_W-1])) begin
         out_in = fin_sum[ACC_W] ? OUT_MIN : OUT_MAX;
      end else begin
         out_in = fin_sum[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_tvalid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && fin_valid_ff) begin
         rsp_tdata_ff <= out_in;
         rsp_tuser_ff <= fin_err_ff ? STATUS_LEN_ERR : STATUS_OK;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> bench/neuron_dot_product_relu_top_tb.sv
// Testbench for neuron_dot_product_relu_top: directed, register-extreme and random row traffic.
// Every result is checked against a predictor kept inside this file.
// Depends on ndpr_pkg and neuron_dot_product_relu_top.
`timescale 1ns / 100ps

module neuron_dot_product_relu_top_tb;
   import ndpr_pkg::*;

   localparam int STORE_DEPTH = MAX_INPUTS_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;   // far above the slowest legal run
   localparam int QUIET_GAP   = 10;       // lets the pipe empty after the last result, with margin

   typedef struct packed {
      logic [OUT_W-1:0] neuron_out;
      logic             status;
   } neuron_result_type;

   // ---------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // weight_slot[7:0], value[23:8]
   logic                  req_tuser  = OP_WEIGHT;   // operation
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // neuron_output[31:0]
   logic                  rsp_tuser;   // status
   logic                  csr_we     = 1'b0;
   logic [CSR_AW-1:0]     csr_addr   = CSR_BIAS;
   logic [CSR_DW-1:0]     csr_wdata  = '0;

   neuron_dot_product_relu_top #(
      .MAX_INPUTS(STORE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: weight store, row accumulator and a shadow of the registers
   // ---------------------------------------------------------------------------
   logic [VALUE_W-1:0]       weight_mem [0:STORE_DEPTH-1];
   bit                       weight_known [0:STORE_DEPTH-1];   // slot written at least once
   longint                   row_sum;
   int                       row_count;
   bit                       row_len_err;
   logic signed [OUT_W-1:0]  cfg_bias;
   logic                     cfg_relu;
   logic [LEN_W-1:0]         cfg_len;

   neuron_result_type        expected_outputs [$];

   // traffic shaping, changed per phase
   int                       send_idle_pct;
   int                       rsp_stall_pct;

   // bookkeeping
   int                       mismatches;
   int                       transactions_sent;
   int                       weight_writes;
   int                       results_checked;
   int                       len_errors_seen;
   int                       cycle_count;

   task automatic report_mismatch(input string what);
      $display("[%0t] ERROR: %s", $time, what);
      mismatches++;
   endtask

   function automatic int effective_row_length();
      return (cfg_len > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_len);
   endfunction

   // Applies one accepted request transaction to the predictor. A row element
   // marked last produces one expected result.
   function automatic void predict_transaction(input logic op, input logic [SLOT_W-1:0] slot,
                                               input logic [VALUE_W-1:0] value,
                                               input logic last);
      longint            prod;
      longint            total;
      int                eff_len;
      bit                err;
      neuron_result_type res;
      eff_len = effective_row_length();
      if (op == OP_WEIGHT) begin
         // last flag is a don't-care on weight writes
         weight_mem[slot]   = value;
         weight_known[slot] = 1'b1;
         return;
      end
      if (row_count < eff_len) begin
         prod    = longint'($signed(value)) * longint'($signed(weight_mem[row_count]));
         row_sum = row_sum + prod;
         if (row_sum > longint'(ACC_MAX)) row_sum = longint'(ACC_MAX);
         if (row_sum < longint'(ACC_MIN)) row_sum = longint'(ACC_MIN);
         row_count++;
      end else begin
         // element past the configured length: dropped, row flagged
         row_len_err = 1'b1;
      end
      if (!last)
         return;
      err   = row_len_err || (row_count != eff_len);
      total = row_sum + longint'(cfg_bias);
      if (cfg_relu && total < 0)         total = 0;
      if (total > longint'(OUT_MAX))     total = longint'(OUT_MAX);
      if (total < longint'(OUT_MIN))     total = longint'(OUT_MIN);
      if (err)                           total = 0;   // bad rows report zero
      res.neuron_out = total[OUT_W-1:0];
      res.status     = err ? STATUS_LEN_ERR : STATUS_OK;
      expected_outputs.push_back(res);
      row_sum     = 0;
      row_count   = 0;
      row_len_err = 1'b0;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // One request transaction; random idle cycles ahead of it, then hold until taken.
   task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, slot};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_transaction(op, slot, value, last);
      transactions_sent++;
      if (op == OP_WEIGHT)
         weight_writes++;
   endtask

   // Register write; only called with the block idle.
   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BIAS: cfg_bias = data[OUT_W-1:0];
         CSR_RELU: cfg_relu = data[0];
         CSR_LEN:  cfg_len  = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Sender stops until every expected result is back, then lets the pipe empty.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (QUIET_GAP) @(posedge clock);
   endtask

   task automatic set_registers(input logic [CSR_DW-1:0] bias, input logic relu,
                                input int len);
      wait_for_results();
      write_reg(CSR_BIAS, bias);
      write_reg(CSR_RELU, {31'd0, relu});
      write_reg(CSR_LEN, CSR_DW'(len));
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Make sure the first n slots hold a weight before a row reads them.
   task automatic fill_missing_weights(input int n);
      for (int i = 0; i < n && i < STORE_DEPTH; i++)
         if (!weight_known[i])
            send_item(OP_WEIGHT, SLOT_W'(i), pick_value(), 1'($urandom));
   endtask

   // A row of n random elements, last flag on the final one. With midrow set,
   // stray weight writes may land between elements.
   task automatic send_row(input int n, input bit midrow);
      fill_missing_weights(n);
      for (int k = 0; k < n; k++) begin
         if (midrow && $urandom_range(0, 19) == 0)
            send_item(OP_WEIGHT, SLOT_W'($urandom), pick_value(), 1'($urandom));
         send_item(OP_ELEMENT, SLOT_W'($urandom), pick_value(), k == n - 1);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random stalls and the per-result check
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      neuron_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%h status=%b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            exp_res = expected_outputs.pop_front();
            results_checked++;
            if (exp_res.status == STATUS_LEN_ERR)
               len_errors_seen++;
            if (rsp_tdata !== exp_res.neuron_out)
               report_mismatch($sformatf("result %0d neuron_output got %h want %h",
                                         results_checked, rsp_tdata, exp_res.neuron_out));
            if (rsp_tuser !== exp_res.status)
               report_mismatch($sformatf("result %0d status got %b want %b",
                                         results_checked, rsp_tuser, exp_res.status));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_outputs.size());
         $display("neuron_dot_product_relu_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Hand-picked rows at length 3: saturation, short and long rows, a weight
   // write with last set, and a weight change in the middle of a row.
   task automatic test_directed();
      set_registers(32'd0, 1'b0, 3);
      send_item(OP_WEIGHT, 8'd0, 16'h8000, 1'b0);
      send_item(OP_WEIGHT, 8'd1, 16'h7FFF, 1'b0);
      send_item(OP_WEIGHT, 8'd2, 16'h8000, 1'b0);
      send_item(OP_WEIGHT, 8'd255, 16'h7FFF, 1'b1);   // last flag ignored on writes
      // two max products: sum exceeds the output range, clips high
      send_item(OP_ELEMENT, 8'hFF, 16'h8000, 1'b0);
      send_item(OP_ELEMENT, 8'h00, 16'h0000, 1'b0);
      send_item(OP_ELEMENT, 8'hFF, 16'h8000, 1'b1);
      // negative sum, identity activation
      send_item(OP_ELEMENT, 8'h00, 16'h7FFF, 1'b0);
      send_item(OP_ELEMENT, 8'h00, 16'h7FFF, 1'b0);
      send_item(OP_ELEMENT, 8'h00, 16'h7FFF, 1'b1);
      // short row
      send_item(OP_ELEMENT, 8'h5A, 16'h1234, 1'b1);
      // long row
      for (int k = 0; k < 4; k++)
         send_item(OP_ELEMENT, 8'hA5, 16'h0F00, k == 3);
      // weight 2 swapped after the first element; the last element sees it
      send_item(OP_ELEMENT, 8'h00, 16'h2000, 1'b0);
      send_item(OP_WEIGHT, 8'd2, 16'h1000, 1'b0);
      send_item(OP_ELEMENT, 8'h00, 16'hE000, 1'b0);
      send_item(OP_ELEMENT, 8'h00, 16'h3000, 1'b1);
   endtask

   // Bias and ReLU at their extremes, zero length, unit length and a length
   // past the store size.
   task automatic test_register_extremes();
      set_registers(32'h8000_0000, 1'b0, 3);   // most negative bias; negative sums clip low
      repeat (3) send_row(3, 1'b0);
      set_registers(32'h8000_0000, 1'b1, 3);   // ReLU floors to zero
      repeat (2) send_row(3, 1'b0);
      set_registers(32'h7FFF_FFFF, 1'b1, 3);
      repeat (2) send_row(3, 1'b0);
      set_registers(32'h0000_1000, 1'b0, 0);   // zero length: every row flagged
      send_row(1, 1'b0);
      send_row(3, 1'b0);
      set_registers(32'hFFFF_F000, 1'b1, 1);
      send_row(1, 1'b0);
      send_row(2, 1'b0);
      send_row(1, 1'b0);
      set_registers(32'h0100_0000, 1'b0, 511); // acts as the store size, short rows flagged
      send_row(3, 1'b0);
      send_row(1, 1'b1);
   endtask

   function automatic int pick_row_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 40);
      return $urandom_range(41, 64);
   endfunction

   function automatic logic [CSR_DW-1:0] pick_bias();
      case ($urandom_range(0, 5))
         0:       return OUT_MIN;
         1:       return OUT_MAX;
         2:       return $urandom;
         default: return CSR_DW'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      endcase
   endfunction

   // Mostly well-formed rows with random content; the rest are long rows,
   // short rows and loose weight writes. One mid-phase drain per phase.
   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int budget);
      int  start;
      int  len;
      int  r;
      bit  drained;
      start   = transactions_sent;
      drained = 1'b0;
      set_registers(pick_bias(), 1'($urandom), pick_row_length());
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      len = effective_row_length();
      while (transactions_sent - start < budget) begin
         r = $urandom_range(0, 99);
         if (r < 75)
            send_row(len, 1'b1);
         else if (r < 85)
            send_row(len + $urandom_range(1, 3), 1'b1);
         else if (r < 93)
            send_row((len > 1) ? $urandom_range(1, len - 1) : 2, 1'b1);
         else
            send_item(OP_WEIGHT, SLOT_W'($urandom), pick_value(), 1'($urandom));
         if (!drained && transactions_sent - start >= budget / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 120);
      run_random_phase(87, 0, 120);
      run_random_phase(0, 87, 120);
      run_random_phase(6, 6, 120);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         weight_mem[i]   = '0;
         weight_known[i] = 1'b0;
      end
      row_sum           = 0;
      row_count         = 0;
      row_len_err       = 1'b0;
      cfg_bias          = '0;
      cfg_relu          = 1'b0;
      cfg_len           = ROW_LENGTH_RESET;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      mismatches        = 0;
      transactions_sent = 0;
      weight_writes     = 0;
      results_checked   = 0;
      len_errors_seen   = 0;
      cycle_count       = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_traffic();
      wait_for_results();

      $display("%0d request transactions (%0d weight writes), %0d results checked",
               transactions_sent, weight_writes, results_checked);
      $display("%0d rows flagged for length, %0d mismatches", len_errors_seen, mismatches);
      if (mismatches == 0 && expected_outputs.size() == 0)
         $display("neuron_dot_product_relu_top: match");
      else
         $display("neuron_dot_product_relu_top: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
sv/ndpr_pkg.sv
sv/neuron_dot_product_relu_top.sv
bench/neuron_dot_product_relu_top_tb.sv
